FILE: src/pfisc_pkg.sv
package pfisc_pkg;

  typedef enum logic [1:0] {
    DEPTH_16 = 2'd0,
    DEPTH_24 = 2'd1,
    DEPTH_32 = 2'd2,
    DEPTH_32X = 2'd3
  } depth_t;

  localparam depth_t DEPTH_RESET = DEPTH_32;

  typedef enum logic {
    REQ_PLAY = 1'b0,
    REQ_CAPT = 1'b1
  } req_t;

  function automatic logic [4:0] scale_exp(input depth_t d);
    case (d)
      DEPTH_16: scale_exp = 5'd15;
      DEPTH_24: scale_exp = 5'd23;
      default:  scale_exp = 5'd31;
    endcase
  endfunction

endpackage

FILE: src/pcm_float_int_sample_converter.sv
// channel | tdata (low->high)                 | tuser
// in_     | float_bits[31:0], pcm_in[63:32]   | req_type
// out_    | pcm_out[31:0], float_out[63:32]   | -
// One beat per clock unless out_tready stalls. Conversion is one combinational
// pass between the input register and the result register.
// rst_n (sync, low) clears valids and sets depth to 32 bit.
// Stalls: a two-stage flow, each stage advances when the next is free.
module pcm_float_int_sample_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // float_bits, pcm_in
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // pcm_out, float_out
);
  import pfisc_pkg::*;

  depth_t      depth_r;
  logic        s1_v_r, s2_v_r;
  logic [63:0] s1_d_r, out_d_r;
  logic        s1_u_r;
  logic [31:0] pcm_c, flt_c;
  logic        s2_ld, s1_ld;

  assign s2_ld = s1_v_r && (!s2_v_r || out_tready);
  assign in_tready = !s1_v_r || s2_ld;
  assign s1_ld = in_tvalid && in_tready;

  pfisc_play u_play (.fb(s1_d_r[31:0]), .depth(depth_r), .pcm(pcm_c));
  pfisc_capt u_capt (.raw(s1_d_r[63:32]), .depth(depth_r), .fout(flt_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_RESET;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      if (cfg_we) depth_r <= depth_t'(cfg_wdata);
      if (s1_ld) s1_v_r <= 1'b1;
      else if (s2_ld) s1_v_r <= 1'b0;
      if (s2_ld) s2_v_r <= 1'b1;
      else if (out_tready) s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_d_r <= in_tdata;
      s1_u_r <= in_tuser;
    end
    if (s2_ld) begin
      out_d_r <= (s1_u_r == REQ_CAPT) ? {flt_c, 32'd0} : {32'd0, pcm_c};
    end
  end

  assign out_tvalid = s2_v_r;
  assign out_tdata  = out_d_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result lost under stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld |=> out_tvalid)
    else $error("stage advance without result");
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:0] == 32'd0 || out_tdata[63:32] == 32'd0))
    else $error("both result fields set");

endmodule

FILE: src/pfisc_play.sv
module pfisc_play (
  input  logic [31:0]      fb,
  input  pfisc_pkg::depth_t depth,
  output logic [31:0]      pcm
);
  import pfisc_pkg::*;

  logic        neg;
  logic [7:0]  ex;
  logic [7:0]  exe;
  logic [22:0] fr;
  logic [4:0]  k;
  logic [23:0] m;
  logic signed [9:0] sh;
  logic        tiny;
  logic [4:0]  rs;
  logic [62:0] wide;
  logic [31:0] mag;
  logic        frac_nz;
  logic [31:0] pmax;

  always_comb begin
    neg  = fb[31];
    ex   = fb[30:23];
    fr   = fb[22:0];
    k    = scale_exp(depth);
    pmax = (32'd1 << k) - 32'd1;
    m    = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
    exe  = (ex == 8'd0) ? 8'd1 : ex;
    // value = m * 2^-sh; for ex < 127, sh ranges from -7 (32 bit) upward
    sh   = 10'sd150 - $signed({2'b00, exe}) - $signed({5'b00000, k});
    // sh >= 24: nonzero value below one, integer part is zero
    tiny = (sh >= 10'sd24);
    rs   = tiny ? 5'd0 : 5'(sh + 10'sd7);
    // integer part in wide[62:32], fraction in wide[31:0]
    wide = {m, 39'd0} >> rs;
    mag  = tiny ? 32'd0 : {1'b0, wide[62:32]};
    frac_nz = tiny ? 1'b1 : (wide[31:0] != 32'd0);
    if (ex == 8'hFF && fr != 23'd0) begin
      pcm = 32'd0;
    end else if (ex >= 8'd127) begin
      pcm = neg ? ~pmax : pmax;
    end else if (m == 24'd0) begin
      pcm = 32'd0;
    end else if (neg) begin
      pcm = -(mag + {31'd0, frac_nz});
    end else begin
      pcm = mag;
    end
  end

endmodule

FILE: src/pfisc_capt.sv
module pfisc_capt (
  input  logic [31:0]      raw,
  input  pfisc_pkg::depth_t depth,
  output logic [31:0]      fout
);
  import pfisc_pkg::*;

  logic [4:0]  k;
  logic [31:0] v;
  logic        neg;
  logic [32:0] a;
  logic [5:0]  p;
  logic [32:0] norm;
  logic [24:0] q;
  logic        g, st;
  logic [7:0]  bexp;

  always_comb begin
    k = scale_exp(depth);
    case (depth)
      DEPTH_16: v = {{16{raw[15]}}, raw[15:0]};
      DEPTH_24: v = {{8{raw[23]}}, raw[23:0]};
      default:  v = raw;
    endcase
    neg = v[31];
    a   = neg ? (33'd0 - {1'b1, v}) : {1'b0, v};
    p = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (a[i]) p = 6'(i);
    end
    norm = a << (6'd32 - p);
    q  = {1'b0, norm[32:9]};
    g  = norm[8];
    st = (norm[7:0] != 8'd0);
    if (g && (st || q[0])) q = q + 25'd1;
    bexp = 8'(p + 6'd0) + 8'd127 - {3'd0, k};
    if (q[24]) begin
      q = q >> 1;
      bexp = bexp + 8'd1;
    end
    if (a == 33'd0) fout = 32'd0;
    else fout = {neg, bexp, q[22:0]};
  end

endmodule
